// ===== rtl/floor_ceiling_texel_mapper_top_macros.svh =====
// Assertion macros for the floor and ceiling texel mapper.
// Used by the front and back modules of the mapper.
`ifndef FLOOR_CEILING_TEXEL_MAPPER_TOP_MACROS_SVH
`define FLOOR_CEILING_TEXEL_MAPPER_TOP_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define FCTM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a next-cycle implication outside reset.
`define FCTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fctm_pkg.sv =====
// Shared types and constants of the floor and ceiling texel mapper.
// No dependencies.
`default_nettype none
package fctm_pkg;
	localparam int unsigned REG_FLOOR_STYLE = 0;
	localparam int unsigned REG_EYE_X       = 1;
	localparam int unsigned REG_EYE_Y       = 2;
	localparam int unsigned REG_EYE_HEIGHT  = 3;
	localparam int unsigned REG_VIEW_PITCH  = 4;
	localparam int unsigned CFG_IDX_W       = 3;
	localparam int unsigned CFG_DATA_W      = 24;

	localparam logic [1:0] STYLE_SINGLE  = 2'd0;
	localparam logic [1:0] STYLE_CHECKER = 2'd1;
	localparam logic [1:0] STYLE_SUM     = 2'd2;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;

	// classified item handed from the front to the back
	typedef struct packed {
		logic [10:0]        column;
		logic [9:0]         row;
		logic               floor_px;
		logic               horizon;
		logic signed [25:0] fx;
		logic signed [25:0] fy;
		logic signed [13:0] num;
		logic signed [13:0] den;
		logic [23:0]        wall_distance;
	} front_item_t;

	typedef struct packed {
		logic              queue_full;
		logic              queue_empty;
	} queue_status_t;
endpackage
`default_nettype wire

// ===== rtl/fctm_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; used by the back part of the mapper.
`default_nettype none
module fctm_divider #(
	parameter int unsigned NUM_W = 40,
	parameter int unsigned DEN_W = 24,
	parameter int unsigned TAG_W = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [NUM_W-1:0] in_num,
	input  wire logic [DEN_W-1:0] in_den,
	input  wire logic [TAG_W-1:0] in_tag,
	output logic                  out_valid,
	output logic [NUM_W-1:0]      out_quot,
	output logic [TAG_W-1:0]      out_tag
);
	logic [NUM_W:0]           vld_q;
	logic [NUM_W-1:0]         num_q [NUM_W+1];
	logic [NUM_W-1:0]         quo_q [NUM_W+1];
	logic [DEN_W:0]           rem_q [NUM_W+1];
	logic [DEN_W-1:0]         den_q [NUM_W+1];
	logic [TAG_W-1:0]         tag_q [NUM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NUM_W-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_q[0] <= in_num;
			den_q[0] <= in_den;
			tag_q[0] <= in_tag;
			quo_q[0] <= '0;
			rem_q[0] <= '0;
		end
	end

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		assign trial = {rem_q[i][DEN_W-1:0], num_q[i][NUM_W-1-i]};
		assign diff  = trial - {1'b0, den_q[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				num_q[i+1] <= num_q[i];
				den_q[i+1] <= den_q[i];
				tag_q[i+1] <= tag_q[i];
				if (!diff[DEN_W]) begin
					rem_q[i+1] <= diff;
					quo_q[i+1] <= quo_q[i] | (NUM_W'(1) << (NUM_W-1-i));
				end else begin
					rem_q[i+1] <= trial;
					quo_q[i+1] <= quo_q[i];
				end
			end
		end
	end

	assign out_valid = vld_q[NUM_W];
	assign out_quot  = quo_q[NUM_W];
	assign out_tag   = tag_q[NUM_W];
endmodule
`default_nettype wire

// ===== rtl/fctm_front.sv =====
// Front part: accepts pixels, classifies them, builds foot point and ratio terms.
// Depends on fctm_pkg.
`default_nettype none
`include "floor_ceiling_texel_mapper_top_macros.svh"
module fctm_front #(
	parameter int unsigned SCREEN_HEIGHT = 512
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [10:0]        column,
	input  wire logic [9:0]         row,
	input  wire logic [7:0]         map_x,
	input  wire logic [7:0]         map_y,
	input  wire logic [15:0]        wall_frac,
	input  wire logic               wall_side,
	input  wire logic               ray_dir_negative,
	input  wire logic [23:0]        wall_distance,
	input  wire logic [10:0]        wall_top,
	input  wire logic signed [11:0] wall_bottom,
	input  wire logic signed [10:0] eye_height,
	input  wire logic signed [10:0] view_pitch,
	output logic                    q_valid,
	input  wire logic               q_pop,
	output fctm_pkg::front_item_t   q_item,
	output fctm_pkg::queue_status_t q_status
);
	localparam logic signed [13:0] SH = 14'(SCREEN_HEIGHT);

	fctm_pkg::front_item_t mem_q [fctm_pkg::QDEPTH];
	logic [fctm_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [fctm_pkg::QPTR_W:0]   cnt_q;
	logic signed [12:0] bot;
	logic               floor_px, keep, push;
	logic signed [13:0] d2;
	fctm_pkg::front_item_t it;

	always_comb begin
		bot = (wall_bottom < 0) ? 13'(SCREEN_HEIGHT) : 13'(wall_bottom);
		floor_px = ($signed({3'b0, row}) >= bot) && ({3'b0, row} < 13'(SCREEN_HEIGHT));
		keep = floor_px || ({1'b0, row} < wall_top);
		d2 = 14'(2) * ($signed({4'b0, row}) - 14'(view_pitch));
		it.column = column;
		it.row = row;
		it.floor_px = floor_px;
		it.wall_distance = (wall_distance == '0) ? 24'd1 : wall_distance;
		if (floor_px) begin
			it.num = SH + 14'(2) * 14'(eye_height);
			it.den = d2 - SH;
		end else begin
			it.num = SH - 14'(2) * 14'(eye_height);
			it.den = SH - d2;
		end
		it.horizon = (it.den == '0);
		if (!wall_side) begin
			it.fx = $signed({2'b0, map_x + 8'(0), 16'b0}) + $signed({9'b0, ray_dir_negative, 16'b0});
			it.fy = $signed({2'b0, map_y, wall_frac});
		end else begin
			it.fx = $signed({2'b0, map_x, wall_frac});
			it.fy = $signed({2'b0, map_y, 16'b0}) + $signed({9'b0, ray_dir_negative, 16'b0});
		end
	end

	assign q_status.queue_full  = (cnt_q == (fctm_pkg::QPTR_W+1)'(fctm_pkg::QDEPTH));
	assign q_status.queue_empty = (cnt_q == '0);
	assign in_stall = q_status.queue_full;
	assign push = in_valid && !in_stall && keep;
	assign q_valid = !q_status.queue_empty;
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= it;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (fctm_pkg::QPTR_W+1)'(push) - (fctm_pkg::QPTR_W+1)'(q_pop);
		end
	end

	`FCTM_ASSERT_IMP(a_no_pop_empty, clk, arst_n, q_pop, q_valid, "pop from empty queue")
	`FCTM_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !q_status.queue_full, "push to full queue")
	`FCTM_ASSERT_NEXT(a_cnt_bound, clk, arst_n, 1'b1,
		cnt_q <= (fctm_pkg::QPTR_W+1)'(fctm_pkg::QDEPTH), "queue count overflow")
endmodule
`default_nettype wire

// ===== rtl/fctm_back.sv =====
// Back part: distance and weight division, blend, texture select (single, checker or sum) and texel wrap.
// Depends on fctm_pkg and fctm_divider.
`default_nettype none
`include "floor_ceiling_texel_mapper_top_macros.svh"
module fctm_back #(
	parameter int unsigned TEX0_WIDTH  = 64,
	parameter int unsigned TEX0_HEIGHT = 64,
	parameter int unsigned TEX1_WIDTH  = 64,
	parameter int unsigned TEX1_HEIGHT = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	output logic                    q_pop,
	input  fctm_pkg::front_item_t   q_item,
	input  wire logic [1:0]         floor_style,
	input  wire logic [23:0]        eye_x,
	input  wire logic [23:0]        eye_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [10:0]             out_column,
	output logic [9:0]              out_row,
	output logic                    is_ceiling,
	output logic                    texture_index,
	output logic [9:0]              tex_u,
	output logic [9:0]              tex_v,
	output logic                    horizon_flag
);
	localparam int unsigned TAG_W = $bits(fctm_pkg::front_item_t) + 1;
	localparam int unsigned Q1_W = 30;
	localparam int unsigned Q2_W = 41;

	logic en;
	assign en = !(out_valid && out_stall);
	assign q_pop = q_valid && en;

	// stage 1: magnitude divide num*2^16 / |den|
	logic [29:0] n1_abs;
	logic [13:0] d1_abs;
	logic        s1_neg;
	always_comb begin
		n1_abs = {(q_item.num < 0) ? 14'(-q_item.num) : q_item.num, 16'b0};
		d1_abs = q_item.horizon ? 14'd1 : ((q_item.den < 0) ? 14'(-q_item.den) : q_item.den);
		s1_neg = q_item.num[13] ^ q_item.den[13];
	end

	logic              d1_v;
	logic [Q1_W-1:0]   d1_q;
	logic [TAG_W-1:0]  d1_t;
	fctm_divider #(.NUM_W(Q1_W), .DEN_W(14), .TAG_W(TAG_W)) u_div_dist (
		.clk, .arst_n, .en,
		.in_valid(q_pop), .in_num(n1_abs), .in_den(d1_abs),
		.in_tag({s1_neg, q_item}),
		.out_valid(d1_v), .out_quot(d1_q), .out_tag(d1_t)
	);

	fctm_pkg::front_item_t it2;
	logic                  neg2;
	logic [24:0]           dmag;
	assign {neg2, it2} = d1_t;
	// saturate distance magnitude: positive to 2^24-1, negative to 2^24
	always_comb begin
		if (neg2) dmag = (d1_q > Q1_W'(25'h1000000)) ? 25'h1000000 : 25'(d1_q);
		else      dmag = (d1_q > Q1_W'(24'hFFFFFF)) ? 25'hFFFFFF : 25'(d1_q);
	end

	logic              d2_v;
	logic [Q2_W-1:0]   d2_q;
	logic [TAG_W-1:0]  d2_t;
	fctm_divider #(.NUM_W(Q2_W), .DEN_W(24), .TAG_W(TAG_W)) u_div_wt (
		.clk, .arst_n, .en,
		.in_valid(d1_v), .in_num({dmag, 16'b0}), .in_den(it2.wall_distance),
		.in_tag(d1_t),
		.out_valid(d2_v), .out_quot(d2_q), .out_tag(d2_t)
	);

	fctm_pkg::front_item_t it3;
	logic                  neg3;
	logic signed [18:0]    w3;
	assign {neg3, it3} = d2_t;
	always_comb begin
		if (it3.horizon) w3 = '0;
		else if (neg3) w3 = (d2_q > Q2_W'(19'h40000)) ? -19'sh40000 : -$signed(19'(d2_q));
		else w3 = (d2_q > Q2_W'(18'h3FFFF)) ? 19'sh3FFFF : 19'(d2_q);
	end

	// stage: products, registered
	logic signed [44:0]    px_s1, py_s1, ex_s1, ey_s1;
	fctm_pkg::front_item_t it_s1;
	logic                  v_s1;
	logic signed [19:0]    omw;
	assign omw = 20'sh10000 - 20'(w3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= d2_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= it3;
			px_s1 <= 45'(w3) * 45'(it3.fx);
			py_s1 <= 45'(w3) * 45'(it3.fy);
			ex_s1 <= 45'(omw) * $signed({21'b0, eye_x});
			ey_s1 <= 45'(omw) * $signed({21'b0, eye_y});
		end
	end

	// stage: sums and floor
	logic signed [45:0] sx, sy;
	logic signed [29:0] cx, cy;
	assign sx = 46'(px_s1) + 46'(ex_s1);
	assign sy = 46'(py_s1) + 46'(ey_s1);
	assign cx = it_s1.horizon ? '0 : 30'(sx >>> 16);
	assign cy = it_s1.horizon ? '0 : 30'(sy >>> 16);

	logic signed [29:0]    cx_s2, cy_s2;
	fctm_pkg::front_item_t it_s2;
	logic                  v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= it_s1;
			cx_s2 <= cx;
			cy_s2 <= cy;
		end
	end

	// texture select and scale
	logic               tex;
	logic signed [30:0] csum;
	assign csum = 31'(cx_s2) + 31'(cy_s2);
	always_comb begin
		if (!it_s2.floor_px) tex = 1'b0;
		else if (floor_style == fctm_pkg::STYLE_SINGLE) tex = 1'b1;
		else if (floor_style == fctm_pkg::STYLE_SUM) tex = csum[16];
		else tex = cx_s2[16] ^ cy_s2[16];
	end
	logic [10:0] tw, th;
	assign tw = tex ? 11'(TEX1_WIDTH) : 11'(TEX0_WIDTH);
	assign th = tex ? 11'(TEX1_HEIGHT) : 11'(TEX0_HEIGHT);

	// fraction times size, upper bits give the wrapped texel
	logic [26:0]           mu_s3, mv_s3;
	logic                  tex_s3, v_s3;
	fctm_pkg::front_item_t it_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			it_s3 <= it_s2;
			tex_s3 <= tex;
			mu_s3 <= 27'(cx_s2[15:0]) * 27'(tw);
			mv_s3 <= 27'(cy_s2[15:0]) * 27'(th);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_column <= it_s3.column;
			out_row <= it_s3.row;
			is_ceiling <= !it_s3.floor_px;
			texture_index <= tex_s3;
			tex_u <= mu_s3[25:16];
			tex_v <= mv_s3[25:16];
			horizon_flag <= it_s3.horizon;
		end
	end

	`FCTM_ASSERT_IMP(a_pop_when_free, clk, arst_n, q_pop, en, "pop while stalled")
	`FCTM_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped")
	`FCTM_ASSERT_IMP(a_horizon_zero, clk, arst_n, out_valid && horizon_flag, tex_u == '0 && tex_v == '0, "horizon texel not zero")
endmodule
`default_nettype wire

// ===== rtl/floor_ceiling_texel_mapper_top.sv =====
// Floor and ceiling texel mapper: one pixel per clock, when not stalled, through a front classifier,
// a four-entry queue and a pipelined back end of restoring dividers, one quotient bit per stage.
// Throughput one item per cycle while neither the input nor the output stalls.
// An output stall with a valid result freezes the back end; the queue takes four items before the input stalls.
// Items on the wall span (not floor and not above wall_top) are dropped at the front and give no result.
// Reset clears valids and queue pointers; registers reset to style 1, all else 0.
`default_nettype none
module floor_ceiling_texel_mapper_top #(
	parameter int unsigned SCREEN_HEIGHT = 512,
	parameter int unsigned TEX0_WIDTH    = 64,
	parameter int unsigned TEX0_HEIGHT   = 64,
	parameter int unsigned TEX1_WIDTH    = 64,
	parameter int unsigned TEX1_HEIGHT   = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [fctm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fctm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [10:0]                    column,
	input  wire logic [9:0]                     row,
	input  wire logic [7:0]                     map_x,
	input  wire logic [7:0]                     map_y,
	input  wire logic [15:0]                    wall_frac,
	input  wire logic                           wall_side,
	input  wire logic                           ray_dir_negative,
	input  wire logic [23:0]                    wall_distance,
	input  wire logic [10:0]                    wall_top,
	input  wire logic signed [11:0]             wall_bottom,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [10:0]                         out_column,
	output logic [9:0]                          out_row,
	output logic                                is_ceiling,
	output logic                                texture_index,
	output logic [9:0]                          tex_u,
	output logic [9:0]                          tex_v,
	output logic                                horizon_flag
);
	logic [1:0]         floor_style_q;
	logic [23:0]        eye_x_q, eye_y_q;
	logic signed [10:0] eye_height_q, view_pitch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_style_q <= fctm_pkg::STYLE_CHECKER;
			eye_x_q <= '0;
			eye_y_q <= '0;
			eye_height_q <= '0;
			view_pitch_q <= '0;
		end else if (cfg_we) begin
			unique case (32'(cfg_index))
				fctm_pkg::REG_FLOOR_STYLE: floor_style_q <= cfg_data[1:0];
				fctm_pkg::REG_EYE_X:       eye_x_q <= cfg_data;
				fctm_pkg::REG_EYE_Y:       eye_y_q <= cfg_data;
				fctm_pkg::REG_EYE_HEIGHT:  eye_height_q <= cfg_data[10:0];
				fctm_pkg::REG_VIEW_PITCH:  view_pitch_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	logic                    q_valid, q_pop;
	fctm_pkg::front_item_t   q_item;
	fctm_pkg::queue_status_t q_status;

	fctm_front #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.column, .row, .map_x, .map_y, .wall_frac, .wall_side, .ray_dir_negative,
		.wall_distance, .wall_top, .wall_bottom,
		.eye_height(eye_height_q), .view_pitch(view_pitch_q),
		.q_valid, .q_pop, .q_item, .q_status
	);

	fctm_back #(
		.TEX0_WIDTH(TEX0_WIDTH), .TEX0_HEIGHT(TEX0_HEIGHT),
		.TEX1_WIDTH(TEX1_WIDTH), .TEX1_HEIGHT(TEX1_HEIGHT)
	) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item,
		.floor_style(floor_style_q), .eye_x(eye_x_q), .eye_y(eye_y_q),
		.out_valid, .out_stall, .out_column, .out_row, .is_ceiling,
		.texture_index, .tex_u, .tex_v, .horizon_flag
	);
endmodule
`default_nettype wire
